@@ src/cst_pkg.sv @@
package cst_pkg;

    localparam int MAX_LEX = 8;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [2:0] KIND_NUMBER   = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_IDENT    = 3'd2;
    localparam logic [2:0] KIND_KEYWORD  = 3'd3;
    localparam logic [2:0] KIND_ASSIGN   = 3'd4;
    localparam logic [2:0] KIND_EOI      = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_NUM   = 2'd1;
    localparam logic [1:0] MODE_IDENT = 2'd2;

    localparam logic [30:0] NUM_SAT = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // keywords, first character in the lowest byte
    localparam logic [63:0] KW_IF     = 64'h0000_0000_0000_6669;
    localparam logic [63:0] KW_ELSE   = 64'h0000_0000_6573_6C65;
    localparam logic [63:0] KW_WHILE  = 64'h0000_0065_6C69_6877;
    localparam logic [63:0] KW_FOR    = 64'h0000_0000_0072_6F66;
    localparam logic [63:0] KW_RETURN = 64'h0000_6E72_7574_6572;

    typedef struct packed {
        logic [2:0]  kind;
        logic [30:0] value;
        logic [63:0] text;
        logic [7:0]  length;
        logic        trunc;
        logic        last;
    } token_t;

    typedef struct packed {
        token_t tok0;
        token_t tok1;
        logic   two;
    } q_entry_t;

    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_write_t;

endpackage

@@ src/character_stream_tokenizer_unit.sv @@
// Character stream tokenizer.
// Input words (s_*): s_tdata carries one source byte, s_tlast marks end of input;
// with s_tlast high the byte is ignored, the pending token is flushed and an
// end-of-input token follows.
// Output words (m_*): one token per word. m_tuser is the token kind, m_tdata holds
// number value, lexeme text (up to MAX_LEX bytes), length and truncation flag;
// m_tlast marks the final token caused by one input word.
// Throughput: one input byte per cycle. A byte may cause zero, one or two tokens;
// the output side moves one token per cycle, so a long run of two-token bytes
// is limited by the output port.
// The queue stores a token when its byte is accepted; the output register then
// loads it, and the second token of a pair waits until the first is taken.
// Between the scanner and the output stage sits a four-entry queue of token
// pairs; s_tready falls only when that queue is full, e.g. while m_tready is low.
// A stalled output holds its word; the scanner keeps running until the queue fills.
// Reset (aresetn low, synchronous) empties the queue, drops any pending token and
// returns the scanner to idle.
module character_stream_tokenizer_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_code
    input  logic         s_tlast,   // end_marker
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // number_value, lexeme_text, lexeme_length,
                                    // lexeme_truncated
    output logic [2:0]   m_tuser,   // token_kind
    output logic         m_tlast    // last_of_run
);
    import cst_pkg::*;

    q_write_t q_wr;
    logic     q_full;

    cst_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    cst_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_wr     (q_wr),
        .q_full   (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/cst_front.sv @@
module cst_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output cst_pkg::q_write_t q_wr
);
    import cst_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [30:0] acc_reg, acc_next;
    logic [63:0] buf_reg, buf_next;
    logic [7:0]  cnt_reg, cnt_next;

    logic        accept;
    logic [7:0]  c;
    logic        is_digit, is_alpha, is_space, is_op;
    logic        is_kw, flush_v, single_v;
    logic [34:0] acc_x10;
    logic [63:0] buf_add;
    logic [7:0]  cnt_add;
    token_t      flush_tok, single_tok, eoi_tok;
    q_entry_t    entry;
    logic        push;

    assign c        = s_tdata;
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_alpha = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
                    || (c == CH_USCORE);
    assign is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    assign is_op    = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR)
                    || (c == CH_SLASH) || (c == CH_PCT);

    assign is_kw = (cnt_reg == 8'd2 && buf_reg == KW_IF)
                || (cnt_reg == 8'd4 && buf_reg == KW_ELSE)
                || (cnt_reg == 8'd5 && buf_reg == KW_WHILE)
                || (cnt_reg == 8'd3 && buf_reg == KW_FOR)
                || (cnt_reg == 8'd6 && buf_reg == KW_RETURN);

    // acc * 10 + digit, never above 35 bits
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {31'b0, c[3:0]};

    always_comb begin
        buf_add = buf_reg;
        for (int i = 0; i < MAX_LEX; i++) begin
            if (cnt_reg == 8'(i)) begin
                buf_add[8*i +: 8] = c;
            end
        end
    end

    assign cnt_add = (cnt_reg == 8'hFF) ? 8'hFF : cnt_reg + 8'd1;
    assign flush_v = (mode_reg != MODE_IDLE);

    always_comb begin
        flush_tok        = '0;
        flush_tok.kind   = (mode_reg == MODE_NUM) ? KIND_NUMBER
                         : (is_kw ? KIND_KEYWORD : KIND_IDENT);
        flush_tok.value  = (mode_reg == MODE_NUM) ? acc_reg : '0;
        flush_tok.text   = buf_reg;
        flush_tok.length = cnt_reg;
        flush_tok.trunc  = (cnt_reg > 8'(MAX_LEX));

        single_tok        = '0;
        single_tok.kind   = is_op ? KIND_OPERATOR : ((c == CH_EQ) ? KIND_ASSIGN : KIND_UNKNOWN);
        single_tok.text   = {56'b0, c};
        single_tok.length = 8'd1;

        eoi_tok      = '0;
        eoi_tok.kind = KIND_EOI;
    end

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        single_v  = 1'b0;
        entry     = '0;
        push      = 1'b0;

        if (s_tlast) begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            buf_next  = '0;
            cnt_next  = '0;
            push      = 1'b1;
            if (flush_v) begin
                entry.tok0      = flush_tok;
                entry.tok1      = eoi_tok;
                entry.tok1.last = 1'b1;
                entry.two       = 1'b1;
            end else begin
                entry.tok0      = eoi_tok;
                entry.tok0.last = 1'b1;
            end
        end else if (mode_reg == MODE_NUM && is_digit) begin
            acc_next = (acc_x10 > {4'b0, NUM_SAT}) ? NUM_SAT : acc_x10[30:0];
            buf_next = buf_add;
            cnt_next = cnt_add;
        end else if (mode_reg == MODE_IDENT && (is_alpha || is_digit)) begin
            buf_next = buf_add;
            cnt_next = cnt_add;
        end else begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            buf_next  = '0;
            cnt_next  = '0;
            if (is_space) begin
                single_v = 1'b0;
            end else if (is_digit) begin
                mode_next = MODE_NUM;
                acc_next  = {27'b0, c[3:0]};
                buf_next  = {56'b0, c};
                cnt_next  = 8'd1;
            end else if (is_alpha) begin
                mode_next = MODE_IDENT;
                buf_next  = {56'b0, c};
                cnt_next  = 8'd1;
            end else begin
                single_v = 1'b1;
            end
            push = flush_v || single_v;
            if (flush_v && single_v) begin
                entry.tok0      = flush_tok;
                entry.tok1      = single_tok;
                entry.tok1.last = 1'b1;
                entry.two       = 1'b1;
            end else if (flush_v) begin
                entry.tok0      = flush_tok;
                entry.tok0.last = 1'b1;
            end else begin
                entry.tok0      = single_tok;
                entry.tok0.last = 1'b1;
            end
        end
    end

    assign q_wr.push  = accept && push;
    assign q_wr.entry = entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            buf_reg  <= '0;
            cnt_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ src/cst_back.sv @@
module cst_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  cst_pkg::q_write_t q_wr,
    output logic              q_full,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [103:0]      m_tdata,   // number_value, lexeme_text, lexeme_length,
                                         // lexeme_truncated
    output logic [2:0]        m_tuser,   // token_kind
    output logic              m_tlast
);
    import cst_pkg::*;

    q_entry_t mem [QDEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, pend_valid_reg;
    token_t            out_tok_reg, pend_tok_reg;
    logic              load, pop;

    assign q_full = (cnt_reg == QCNT_W'(QDEPTH));
    assign load   = !out_valid_reg || m_tready;
    assign pop    = load && !pend_valid_reg && (cnt_reg != '0);

    always_comb begin
        cnt_next = cnt_reg;
        if (q_wr.push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (!q_wr.push && pop) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            mem[wr_ptr_reg] <= q_wr.entry;
        end
        if (load) begin
            if (pend_valid_reg) begin
                out_tok_reg <= pend_tok_reg;
            end else if (pop) begin
                out_tok_reg  <= mem[rd_ptr_reg].tok0;
                pend_tok_reg <= mem[rd_ptr_reg].tok1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (q_wr.push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (load) begin
                out_valid_reg  <= pend_valid_reg || (cnt_reg != '0);
                pend_valid_reg <= pop && mem[rd_ptr_reg].two;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tok_reg.trunc, out_tok_reg.length, out_tok_reg.text,
                       out_tok_reg.value};
    assign m_tuser  = out_tok_reg.kind;
    assign m_tlast  = out_tok_reg.last;

    a_pend_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("second token held without a first on the output");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (!out_tok_reg.last && pend_tok_reg.last))
        else $error("last flag misplaced within a token pair");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_wr.push)
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

@@ test/token_stream_checker.sv @@
module token_stream_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_code
    input  logic         s_tlast,   // end_marker
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,   // number_value, lexeme_text, lexeme_length,
                                    // lexeme_truncated
    input  logic [2:0]   m_tuser,   // token_kind
    input  logic         m_tlast,   // last_of_run
    output int           mismatches,
    output int           tokens_due
);
    import cst_pkg::*;

    logic [1:0]  scan_mode;
    logic [30:0] num_acc;
    logic [63:0] lex_text;
    logic [7:0]  lex_len;
    token_t      expected_tokens[$];
    int          err_tally;
    int          token_no;

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_word_start(logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_arith(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH || c == CH_PCT;
    endfunction

    function automatic logic is_keyword();
        if (lex_len > MAX_LEX) return 1'b0;
        return (lex_len == 8'd2 && lex_text == KW_IF) ||
               (lex_len == 8'd4 && lex_text == KW_ELSE) ||
               (lex_len == 8'd5 && lex_text == KW_WHILE) ||
               (lex_len == 8'd3 && lex_text == KW_FOR) ||
               (lex_len == 8'd6 && lex_text == KW_RETURN);
    endfunction

    function automatic token_t make_token(logic [2:0] kind, logic [30:0] value,
                                          logic [63:0] text, logic [7:0] len);
        token_t t;
        t.kind   = kind;
        t.value  = value;
        t.text   = text;
        t.length = len;
        t.trunc  = len > MAX_LEX;
        t.last   = 1'b0;
        return t;
    endfunction

    task automatic add_lex_char(input logic [7:0] c);
        if (lex_len < MAX_LEX) lex_text[8 * lex_len +: 8] = c;
        if (lex_len != 8'hFF) lex_len = lex_len + 8'd1;
    endtask

    task automatic lex_word(input logic [7:0] c, input logic eoi);
        token_t      made [0:1];
        int          n;
        int unsigned d;
        logic        flushes;
        n = 0;
        flushes = eoi || !((scan_mode == MODE_NUM && is_digit(c)) ||
                           (scan_mode == MODE_IDENT && (is_word_start(c) || is_digit(c))));
        if (!flushes) begin
            if (scan_mode == MODE_NUM) begin
                d = c - CH_ZERO;
                if (num_acc > (NUM_SAT - d) / 10) num_acc = NUM_SAT;
                else num_acc = 31'(num_acc * 10 + d);
            end
            add_lex_char(c);
        end else begin
            if (scan_mode == MODE_NUM) begin
                made[n] = make_token(KIND_NUMBER, num_acc, lex_text, lex_len);
                n++;
            end else if (scan_mode == MODE_IDENT) begin
                made[n] = make_token(is_keyword() ? KIND_KEYWORD : KIND_IDENT, '0,
                                     lex_text, lex_len);
                n++;
            end
            scan_mode = MODE_IDLE;
            num_acc   = '0;
            lex_text  = '0;
            lex_len   = '0;
            if (eoi) begin
                made[n] = make_token(KIND_EOI, '0, '0, '0);
                n++;
            end else if (!is_blank(c)) begin
                if (is_digit(c)) begin
                    scan_mode = MODE_NUM;
                    num_acc   = 31'(c - CH_ZERO);
                    add_lex_char(c);
                end else if (is_word_start(c)) begin
                    scan_mode = MODE_IDENT;
                    add_lex_char(c);
                end else begin
                    made[n] = make_token(is_arith(c) ? KIND_OPERATOR :
                                         (c == CH_EQ ? KIND_ASSIGN : KIND_UNKNOWN),
                                         '0, {56'd0, c}, 8'd1);
                    n++;
                end
            end
        end
        if (n > 0) made[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_tokens.push_back(made[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_tally < 200)
            $display("token %0d: %s is %h, expected %h", token_no, what, got, want);
        err_tally++;
    endtask

    always @(posedge aclk) begin
        token_t due;
        if (!aresetn) begin
            scan_mode = MODE_IDLE;
            num_acc   = '0;
            lex_text  = '0;
            lex_len   = '0;
            expected_tokens.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("word with none due, kind", m_tuser, '0);
                end else begin
                    due = expected_tokens.pop_front();
                    if (m_tuser !== due.kind) report_mismatch("kind", m_tuser, due.kind);
                    if (m_tdata[30:0] !== due.value)
                        report_mismatch("value", m_tdata[30:0], due.value);
                    if (m_tdata[94:31] !== due.text)
                        report_mismatch("text", m_tdata[94:31], due.text);
                    if (m_tdata[102:95] !== due.length)
                        report_mismatch("length", m_tdata[102:95], due.length);
                    if (m_tdata[103] !== due.trunc)
                        report_mismatch("truncated", m_tdata[103], due.trunc);
                    if (m_tlast !== due.last) report_mismatch("tlast", m_tlast, due.last);
                end
                token_no++;
            end
            if (s_tvalid && s_tready) lex_word(s_tdata, s_tlast);
        end
        mismatches <= err_tally;
        tokens_due <= expected_tokens.size();
    end

endmodule

@@ test/character_stream_tokenizer_unit_tb.sv @@
module character_stream_tokenizer_unit_tb;
    import cst_pkg::*;

    localparam int ITEMS       = 1350;
    localparam int CYCLE_LIMIT = 500000;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'd0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    int    mismatches;
    int    tokens_due;
    int    cycles     = 0;
    int    words_sent = 0;
    logic  send_burst = 1'b0;
    logic  take_burst = 1'b0;

    string digits      = "0123456789";
    string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string stray_chars = "();{}<>!\"#$&'.,:?@[\\]^`|~";
    string arith_chars = "+-*/%=";
    string keywords [5]    = '{"if", "else", "while", "for", "return"};
    string sat_numbers [4] = '{"2147483647", "2147483648", "99999999999", "000000000012"};

    character_stream_tokenizer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    token_stream_checker token_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .tokens_due (tokens_due)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic feed_char(input logic [7:0] c, input logic eoi);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++) feed_char(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 3) == 0) return digits[$urandom_range(0, 9)];
        return word_chars[$urandom_range(0, word_chars.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_stray();
        case ($urandom_range(0, 4))
            0:       return stray_chars[$urandom_range(0, stray_chars.len() - 1)];
            1:       return 8'($urandom_range(128, 255));
            2:       return 8'($urandom_range(1, 8));
            3:       return 8'($urandom_range(14, 31));
            default: return 8'h00;
        endcase
    endfunction

    // one lexeme-sized chunk; adjacent chunks are not separated on purpose
    task automatic emit_random_lexeme();
        int    pick;
        int    len;
        int    tweak;
        string s;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            if ($urandom_range(0, 9) == 0) begin
                feed_text(sat_numbers[$urandom_range(0, 3)]);
            end else begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 13) : $urandom_range(1, 4);
                repeat (len) feed_char(digits[$urandom_range(0, 9)], 1'b0);
            end
        end else if (pick < 44) begin
            if ($urandom_range(0, 79) == 0) len = $urandom_range(254, 262);
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(6, 11);
            else len = $urandom_range(0, 5);
            feed_char(word_chars[$urandom_range(0, word_chars.len() - 1)], 1'b0);
            repeat (len) feed_char(rand_alnum(), 1'b0);
        end else if (pick < 54) begin
            s = keywords[$urandom_range(0, 4)];
            tweak = $urandom_range(0, 5);
            if (tweak == 1) feed_text(s.substr(0, s.len() - 2));
            else feed_text(s);
            if (tweak == 0) feed_char(rand_alnum(), 1'b0);
        end else if (pick < 66) begin
            feed_char(arith_chars[$urandom_range(0, arith_chars.len() - 1)], 1'b0);
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 3)) feed_char(rand_blank(), 1'b0);
        end else if (pick < 88) begin
            feed_char(rand_stray(), 1'b0);
        end else if (pick < 94) begin
            feed_char(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            feed_char(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        int gap;
        repeat (10) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
            gap = take_burst ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero byte and top byte are both stray characters
        feed_char(8'h00, 1'b0);
        feed_char(8'hFF, 1'b0);
        feed_text(arith_chars);
        feed_char(CH_SPACE, 1'b0);
        feed_char(CH_TAB, 1'b0);
        feed_char(CH_LF, 1'b0);
        feed_char(CH_CR, 1'b0);
        feed_text("if");
        feed_char(CH_SPACE, 1'b0);
        feed_text("_9z");
        // end flushes the identifier, a second end stands alone
        feed_char(8'h00, 1'b1);
        feed_char(8'hFF, 1'b1);
        feed_text("7");
        feed_char(8'h5A, 1'b1);

        target = words_sent + ITEMS;
        while (words_sent < target) emit_random_lexeme();
        feed_char(8'($urandom_range(0, 255)), 1'b1);
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (tokens_due != 0);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
